// File: design/swmsm_pkg.sv
// ----------------------------------------------------------------------------
// swmsm_pkg
// Shared widths, defaults and types for the sliding window mean square meter.
// ----------------------------------------------------------------------------
package swmsm_pkg;

	localparam int DEF_MAX_WINDOW  = 65536;
	localparam int DEF_SAMPLE_BITS = 24;

	localparam int SQ_W   = 47;
	localparam int SUM_W  = 63;
	localparam int CNT_W  = 17;
	localparam int WLEN_W = 17;

	localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(6000);

	// result transaction: mean_square, peak_square, fill_count, padded to bytes
	localparam int OUT_FIELDS_W = SQ_W + SQ_W + CNT_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// restoring divider, several quotient bits per cycle
	localparam int DIV_W    = SUM_W + 1;
	localparam int DIV_STEP = 4;
	localparam int DIV_ITER = DIV_W / DIV_STEP;
	localparam int IT_W     = $clog2(DIV_ITER);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_UPD  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

endpackage

// File: design/swmsm_ram.sv
// ----------------------------------------------------------------------------
// swmsm_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swmsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/sliding_window_mean_square_meter.sv
// ----------------------------------------------------------------------------
// sliding_window_mean_square_meter
// Squares samples into a ring memory, keeps a running window sum, fill count
// and peak square, and reports sum / count per transaction.
//
//   channel   dir  signals                         payload
//   s_*       in   s_tvalid s_tready s_tdata s_tuser  sample, clear
//   m_*       out  m_tvalid m_tready m_tdata          mean, peak, fill count
//   cfg_*     in   cfg_we cfg_wdata                   window_length
//
// a sample transaction: accept with ring read, update with ring write,
// 16 divider iterations (4 quotient bits each), output load. a clear
// transaction: accept, then output load. the result register frees the input
// side while a result waits; the output load stalls only while the previous
// result is still untaken. reset needs no clearing pass of the ring.
// ----------------------------------------------------------------------------
module sliding_window_mean_square_meter
	import swmsm_pkg::*;
#(
	parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample
	input  logic                                    s_tuser,  // clear
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [OUT_TDATA_W-1:0]                  m_tdata,  // mean_square, peak_square, fill_count
	input  logic                                    cfg_we,
	input  logic [WLEN_W-1:0]                       cfg_wdata
);

	localparam int AW = $clog2(MAX_WINDOW);

	state_t state_q;

	logic [WLEN_W-1:0] wlen_q;
	logic [AW-1:0]     pos_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   peak_q;
	logic              m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic [SQ_W-1:0]   sq_s1;
	logic              full_s1;

	logic [DIV_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [IT_W-1:0]   it_q;

	logic [WLEN_W-1:0] eff_len;
	logic [SAMPLE_BITS-1:0]   sample;
	logic [SAMPLE_BITS-1:0]   mag;
	logic [2*SAMPLE_BITS-1:0] mag_ext;
	logic [2*SAMPLE_BITS-1:0] prod;
	logic [SQ_W-1:0]   sq;
	logic              in_xfer;
	logic              out_free;

	logic [SQ_W-1:0]   rd_data;
	logic [SQ_W-1:0]   dropped;
	logic [SUM_W-1:0]  sum_n;
	logic [SQ_W-1:0]   peak_n;
	logic [CNT_W-1:0]  cnt_n;
	logic [AW-1:0]     pos_n;

	logic [DIV_W-1:0]  dvd_n;
	logic [CNT_W-1:0]  rem_n;
	logic [CNT_W:0]    trial;
	logic [SQ_W-1:0]   mean;

	// effective window length, 1 .. MAX_WINDOW
	always_comb begin
		if (wlen_q == '0) begin
			eff_len = WLEN_W'(1);
		end else if (32'(wlen_q) > MAX_WINDOW) begin
			eff_len = WLEN_W'(MAX_WINDOW);
		end else begin
			eff_len = wlen_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// square of the sign magnitude
	assign sample  = s_tdata[SAMPLE_BITS-1:0];
	assign mag     = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
	assign mag_ext = {{SAMPLE_BITS{1'b0}}, mag};
	assign prod    = mag_ext * mag_ext;
	assign sq      = SQ_W'(prod);

	swmsm_ram #(
		.WIDTH (SQ_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_UPD),
		.waddr (pos_q),
		.wdata (sq_s1),
		.re    (in_xfer),
		.raddr (pos_q),
		.rdata (rd_data)
	);

	// window update with the dropped square
	always_comb begin
		dropped = full_s1 ? rd_data : '0;
		sum_n   = sum_q - SUM_W'(dropped) + SUM_W'(sq_s1);
		peak_n  = (peak_q == dropped) ? sq_s1 : peak_q;
		if (sq_s1 > peak_n) begin
			peak_n = sq_s1;
		end
		cnt_n = full_s1 ? cnt_q : cnt_q + 1'b1;
		if (32'(pos_q) + 32'd1 == 32'(eff_len)) begin
			pos_n = '0;
		end else begin
			pos_n = pos_q + 1'b1;
		end
	end

	// restoring division step group
	always_comb begin
		dvd_n = dvd_q;
		rem_n = rem_q;
		trial = '0;
		for (int i = 0; i < DIV_STEP; i++) begin
			trial = {rem_n, dvd_n[DIV_W-1]};
			dvd_n = {dvd_n[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, cnt_q}) begin
				trial    = trial - {1'b0, cnt_q};
				dvd_n[0] = 1'b1;
			end
			rem_n = trial[CNT_W-1:0];
		end
	end

	assign mean = (cnt_q == '0) ? '0 : dvd_q[SQ_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wlen_q     <= WLEN_RESET;
			pos_q      <= '0;
			cnt_q      <= '0;
			sum_q      <= '0;
			peak_q     <= '0;
			m_tvalid_q <= 1'b0;
			it_q       <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				wlen_q <= cfg_wdata;
				pos_q  <= '0;
				cnt_q  <= '0;
				sum_q  <= '0;
				peak_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (s_tuser) begin
							pos_q   <= '0;
							cnt_q   <= '0;
							sum_q   <= '0;
							peak_q  <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					sum_q   <= sum_n;
					peak_q  <= peak_n;
					cnt_q   <= cnt_n;
					pos_q   <= pos_n;
					it_q    <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					it_q <= it_q + 1'b1;
					if (it_q == IT_W'(DIV_ITER - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sq_s1   <= sq;
			full_s1 <= (cnt_q >= eff_len);
		end
		if (state_q == ST_UPD) begin
			dvd_q <= {1'b0, sum_n};
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= OUT_TDATA_W'({cnt_q, peak_q, mean});
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_count_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= eff_len)
		else $error("fill count above window length");

	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < 32'(eff_len))
		else $error("write position outside window");

	a_sample_updates: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !s_tuser) |=> (state_q == ST_UPD))
		else $error("sample transaction skipped ring update");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q != '0) |-> (rem_q < cnt_q))
		else $error("divider remainder not below divisor");

endmodule

// File: bench/sliding_window_mean_square_meter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_mean_square_meter_test
// Drives sample and clear transactions through the meter. Random gaps on the
// sample stream and random back-pressure on the result stream, plus one long
// result hold. The bench models the ring, running sum, fill count and peak
// tracking itself and checks every result, field by field, in arrival order.
// Window lengths cover zero, one, small wrapping windows, the maximum and
// out-of-range values.
// ----------------------------------------------------------------------------
module sliding_window_mean_square_meter_test;
	import swmsm_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 24;

	typedef struct {
		bit [SQ_W-1:0]  mean;
		bit [SQ_W-1:0]  peak;
		bit [CNT_W-1:0] fill;
	} level_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [23:0]            s_tdata = '0;  // sample
	logic                   s_tuser = 1'b0;  // clear
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;  // mean_square, peak_square, fill_count
	logic                   cfg_we = 1'b0;
	logic [WLEN_W-1:0]      cfg_wdata = '0;

	// meter state as the bench sees it
	bit [SQ_W-1:0]   ring_sq [DEF_MAX_WINDOW];
	bit [15:0]       ring_pos;
	bit [CNT_W-1:0]  held_count;
	bit [SUM_W-1:0]  window_sum;
	bit [SQ_W-1:0]   peak_sq;
	bit [WLEN_W-1:0] window_len;

	level_t expected_levels[$];
	int     mismatch_count = 0;
	int     cycle_count = 0;
	bit     send_steady = 1'b0;
	bit     recv_steady = 1'b0;
	int     hold_cycles = 0;
	int     stall_left = 0;

	sliding_window_mean_square_meter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 50);
	endfunction

	function automatic logic [23:0] rand_sample();
		int          r;
		logic [23:0] v;
		r = $urandom_range(0, 99);
		if (r < 45)
			v = 24'($urandom);
		else if (r < 80)
			v = 24'($urandom_range(0, 300));
		else if (r < 95)
			v = 24'($urandom_range(0, 65536));
		else begin
			case ($urandom_range(0, 3))
				0: v = 24'h800000;
				1: v = 24'h7FFFFF;
				2: v = 24'h000000;
				default: v = 24'hFFFFFF;
			endcase
		end
		if (r >= 45 && r < 95 && $urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	task automatic clear_meter();
		ring_pos   = '0;
		held_count = '0;
		window_sum = '0;
		peak_sq    = '0;
	endtask

	task automatic predict_level(input logic [23:0] smp, input bit clr);
		bit [16:0]      len;
		bit [24:0]      mag;
		bit [SQ_W-1:0]  sq;
		bit [SQ_W-1:0]  dropped;
		bit [16:0]      pos;
		level_t         lv;
		if (clr) begin
			clear_meter();
		end else begin
			len = window_len;
			if (len == 0)
				len = 17'd1;
			if (len > DEF_MAX_WINDOW)
				len = 17'(DEF_MAX_WINDOW);
			mag = smp[23] ? (25'h1000000 - {1'b0, smp}) : {1'b0, smp};
			sq = SQ_W'({25'd0, mag} * {25'd0, mag});
			pos = ring_pos % len;
			dropped = '0;
			if (held_count >= len)
				dropped = ring_sq[pos[15:0]];
			ring_sq[pos[15:0]] = sq;
			ring_pos = 16'((pos + 17'd1) % len);
			window_sum = window_sum - dropped + sq;
			if (peak_sq == dropped)
				peak_sq = sq;
			if (sq > peak_sq)
				peak_sq = sq;
			if (held_count < len)
				held_count = held_count + 1'b1;
		end
		lv.mean = (held_count != 0) ? SQ_W'(window_sum / held_count) : '0;
		lv.peak = peak_sq;
		lv.fill = held_count;
		expected_levels.push_back(lv);
	endtask

	// result side: random stalls, plus the long hold when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles = hold_cycles - 1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left = stall_left - 1;
			end else if (!recv_steady && $urandom_range(0, 99) < 15) begin
				m_tready <= 1'b0;
				stall_left = pick_gap();
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		level_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_levels.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = expected_levels.pop_front();
				if (m_tdata[SQ_W-1:0] !== want.mean) begin
					$display("%0t: mean_square expected %0d actual %0d",
						$time, want.mean, m_tdata[SQ_W-1:0]);
					mismatch_count++;
				end
				if (m_tdata[2*SQ_W-1:SQ_W] !== want.peak) begin
					$display("%0t: peak_square expected %0d actual %0d",
						$time, want.peak, m_tdata[2*SQ_W-1:SQ_W]);
					mismatch_count++;
				end
				if (m_tdata[2*SQ_W+CNT_W-1:2*SQ_W] !== want.fill) begin
					$display("%0t: fill_count expected %0d actual %0d",
						$time, want.fill, m_tdata[2*SQ_W+CNT_W-1:2*SQ_W]);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_item(input logic [23:0] smp, input bit clr);
		int gap;
		gap = send_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= clr;
		do
			@(posedge clk);
		while (!s_tready);
		predict_level(smp, clr);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input bit [WLEN_W-1:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we     <= 1'b0;
		window_len = v;
		clear_meter();
	endtask

	task automatic run_phase(input bit [WLEN_W-1:0] wlen, input int count, input bit steady);
		write_window(wlen);
		send_steady = steady;
		recv_steady = steady;
		repeat (count)
			send_item(rand_sample(), $urandom_range(0, 99) < 3);
		send_steady = 1'b0;
		recv_steady = 1'b0;
	endtask

	task automatic test_reset_window();
		send_item(24'h000000, 1'b0);
		send_item(24'h000001, 1'b0);
		send_item(24'hFFFFFF, 1'b0);
		send_item(24'h7FFFFF, 1'b0);
		send_item(24'h800000, 1'b0);
		send_item(24'h555555, 1'b0);
		send_item(24'hAAAAAA, 1'b0);
		send_item(24'h3C5A96, 1'b1);
		send_item(24'h123456, 1'b0);
	endtask

	// peak leaves the window and is replaced by the newest square
	task automatic test_peak_drop();
		write_window(WLEN_W'(3));
		send_item(24'd100, 1'b0);
		send_item(24'd1, 1'b0);
		send_item(24'd2, 1'b0);
		send_item(24'd3, 1'b0);
		send_item(-24'sd3, 1'b0);
		send_item(24'd3, 1'b0);
		send_item(24'd3, 1'b0);
		send_item(24'd3, 1'b0);
		send_item(24'd0, 1'b1);
		send_item(24'd9, 1'b0);
	endtask

	task automatic test_window_bounds();
		write_window(WLEN_W'(0));
		send_item(24'd4, 1'b0);
		send_item(-24'sd5, 1'b0);
		write_window({WLEN_W{1'b1}});
		send_item(24'h7FFFFF, 1'b0);
		send_item(24'h800000, 1'b0);
		write_window(WLEN_W'(DEF_MAX_WINDOW));
		send_item(24'd1, 1'b0);
		send_item(24'd2, 1'b0);
	endtask

	task automatic test_random_windows();
		run_phase(WLEN_W'(1), 60, 1'b0);
		run_phase(WLEN_W'(2), 80, 1'b0);
		run_phase(WLEN_W'(3), 80, 1'b1);
		run_phase(WLEN_W'(4), 80, 1'b0);
		run_phase(WLEN_W'(7), 80, 1'b0);
		run_phase(WLEN_W'(16), 100, 1'b0);
		run_phase(WLEN_W'(33), 100, 1'b1);
		run_phase(WLEN_W'(100), 150, 1'b0);
		run_phase(WLEN_W'(255), 300, 1'b0);
		run_phase(WLEN_W'($urandom_range(5, 64)), 80, 1'b0);
		run_phase(WLEN_W'($urandom_range(65, 1000)), 100, 1'b0);
		run_phase(WLEN_W'($urandom_range(1, DEF_MAX_WINDOW)), 20, 1'b0);
		run_phase(WLEN_W'($urandom_range(DEF_MAX_WINDOW + 1, 131071)), 20, 1'b0);
	endtask

	// results held back long enough that the input side stalls
	task automatic test_backpressure();
		write_window(WLEN_W'(5));
		hold_cycles = 400;
		send_steady = 1'b1;
		repeat (40)
			send_item(rand_sample(), 1'b0);
		send_steady = 1'b0;
	endtask

	initial begin
		window_len = WLEN_RESET;
		clear_meter();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_window();
		test_peak_drop();
		test_window_bounds();
		test_random_windows();
		test_backpressure();
		drain();
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
